/* design/ctb_pkg.sv */
// ctb_pkg: shared types and constants for the countdown timer bank
// holds command, slot status and sequencer encodings plus the result and control structs
// no dependencies
package ctb_pkg;

    localparam int CMD_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int VALUE_W = 16;
    localparam int CODE_W  = 8;
    localparam int OUT_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_SET    = 3'd2,
        CMD_GET    = 3'd3,
        CMD_PAUSE  = 3'd4,
        CMD_RESUME = 3'd5,
        CMD_STOP   = 3'd6,
        CMD_NOP    = 3'd7
    } ctb_cmd_t;

    typedef enum logic [1:0] {
        SLOT_IDLE   = 2'd0,
        SLOT_RUN    = 2'd1,
        SLOT_PAUSE  = 2'd2,
        SLOT_QUEUED = 2'd3
    } ctb_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD_WAIT,
        ST_CMD_EX,
        ST_WALK,
        ST_ARM,
        ST_Q_SLOT,
        ST_C_WAIT,
        ST_C_DATA,
        ST_EMIT
    } ctb_state_t;

    typedef struct packed {
        logic [OUT_W-1:0]  count;
        logic              error;
        logic              exp_valid;
        logic [SLOT_W-1:0] exp_slot;
        logic [CODE_W-1:0] exp_code;
    } ctb_result_t;

    typedef struct packed {
        logic cnt_we;
        logic code_we;
    } ctb_mem_ctrl_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ctb_fifo_ctrl_t;

    typedef struct packed {
        logic run;
        logic expire;
    } ctb_tick_flags_t;

endpackage

/* design/ctb_tick_unit.sv */
// ctb_tick_unit: shared decrement and expiry compare, reused for every slot of a tick walk
// depends on ctb_pkg
module ctb_tick_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  ctb_pkg::ctb_status_t     status,
    input  logic [COUNT_WIDTH-1:0]   count_in,
    output ctb_pkg::ctb_tick_flags_t flags,
    output logic [COUNT_WIDTH-1:0]   count_new
);
    import ctb_pkg::*;

    always_comb
    begin
        flags.run    = (status == SLOT_RUN);
        flags.expire = flags.run && (count_in <= COUNT_WIDTH'(1));
        if (count_in <= COUNT_WIDTH'(1))
        begin
            count_new = '0;
        end
        else
        begin
            count_new = count_in - COUNT_WIDTH'(1);
        end
    end

endmodule

/* design/ctb_slot_mem.sv */
// ctb_slot_mem: per-slot count and expiry code memories with registered read
// count entries carry written bits so unwritten counts read as zero; depends on ctb_pkg
module ctb_slot_mem #(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 16,
    parameter int IW          = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctb_pkg::ctb_mem_ctrl_t        ctrl,
    input  logic [IW-1:0]                 waddr,
    input  logic [COUNT_WIDTH-1:0]        cnt_wdata,
    input  logic [ctb_pkg::CODE_W-1:0]    code_wdata,
    input  logic [IW-1:0]                 raddr,
    output logic [COUNT_WIDTH-1:0]        cnt_rdata,
    output logic [ctb_pkg::CODE_W-1:0]    code_rdata
);
    import ctb_pkg::*;

    logic [COUNT_WIDTH-1:0] cnt_mem [NUM_TIMERS];
    logic [CODE_W-1:0]      code_mem [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic [CODE_W-1:0]      code_rd_reg;
    logic [NUM_TIMERS-1:0]  written_reg;
    logic                   written_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cnt_we)
        begin
            cnt_mem[waddr] <= cnt_wdata;
        end
        if (ctrl.code_we)
        begin
            code_mem[waddr] <= code_wdata;
        end
        cnt_rd_reg  <= cnt_mem[raddr];
        code_rd_reg <= code_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            written_rd_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cnt_we)
            begin
                written_reg[waddr] <= 1'b1;
            end
            written_rd_reg <= written_reg[raddr];
        end
    end

    assign cnt_rdata  = written_rd_reg ? cnt_rd_reg : '0;
    assign code_rdata = code_rd_reg;

endmodule

/* design/ctb_expiry_fifo.sv */
// ctb_expiry_fifo: circular queue of expired slot numbers with registered head read
// depends on ctb_pkg
module ctb_expiry_fifo #(
    parameter int NUM_TIMERS = 8,
    parameter int IW         = 3,
    parameter int FW         = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctb_pkg::ctb_fifo_ctrl_t ctrl,
    input  logic [IW-1:0]           push_data,
    output logic [IW-1:0]           head_data,
    output logic [FW-1:0]           fill
);
    import ctb_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

    logic [IW-1:0] queue_mem [NUM_TIMERS];
    logic [IW-1:0] head_reg;
    logic [IW-1:0] tail_reg;
    logic [FW-1:0] fill_reg;
    logic [IW-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            queue_mem[tail_reg] <= push_data;
        end
        rd_reg <= queue_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                tail_reg <= (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
                fill_reg <= fill_reg + FW'(1);
            end
            else if (ctrl.pop)
            begin
                head_reg <= (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

    assign head_data = rd_reg;
    assign fill      = fill_reg;

endmodule

/* design/countdown_timer_bank_unit.sv */
// countdown_timer_bank_unit: a slot request reads the count memory, executes, then emits; a no-op or
// disarmed tick emits directly; an armed tick walks all slots, then delivers a queued expiry with its code;
// the walk reads one slot count a cycle through the count memory port and the shared unit
// one request at a time: the next is taken the cycle after its result is registered
// reset: all slots idle, counts zero, expiry queue empty, tick disarmed; no clearing pass
module countdown_timer_bank_unit #(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ctb_pkg::CMD_W-1:0]   command,
    input  logic [ctb_pkg::SLOT_W-1:0]  slot,
    input  logic [ctb_pkg::VALUE_W-1:0] value,
    input  logic [ctb_pkg::CODE_W-1:0]  start_code,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ctb_pkg::OUT_W-1:0]   count_out,
    output logic                        error,
    output logic                        expiry_valid,
    output logic [ctb_pkg::SLOT_W-1:0]  expiry_slot,
    output logic [ctb_pkg::CODE_W-1:0]  expiry_code
);
    import ctb_pkg::*;

    // slot index and counter widths
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int FW = $clog2(NUM_TIMERS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

    // sequencer and request capture
    ctb_state_t             state_reg, state_next;
    ctb_cmd_t               cmd_reg, cmd_next;
    logic [COUNT_WIDTH-1:0] val_reg, val_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic                   ok_reg, ok_next;

    // read index leads, write index trails by one during the walk
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          wr_idx_reg, wr_idx_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic                   issue_done_reg, issue_done_next;

    // bank-wide state
    ctb_status_t            status_reg [NUM_TIMERS];
    ctb_status_t            status_next [NUM_TIMERS];
    logic [FW-1:0]          run_cnt_reg, run_cnt_next;
    logic                   armed_reg, armed_next;

    // pending result and output register
    ctb_result_t            res_reg, res_next;
    ctb_result_t            out_res_reg, out_res_next;
    logic                   out_valid_reg, out_valid_next;

    // memory, queue and shared unit hookup
    ctb_mem_ctrl_t          mem_ctrl;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] mem_cnt;
    logic [CODE_W-1:0]      mem_code;
    ctb_fifo_ctrl_t         fifo_ctrl;
    logic [IW-1:0]          fifo_head;
    logic [FW-1:0]          fifo_fill;
    ctb_tick_flags_t        tick_flags;
    logic [COUNT_WIDTH-1:0] tick_count;

    // request decode
    logic                   accept;
    logic                   in_slot_ok;
    logic [IW-1:0]          in_idx;
    ctb_status_t            cur_st;
    logic [COUNT_WIDTH-1:0] start_cnt;

    ctb_slot_mem #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IW          (IW)
    ) u_slot_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mem_ctrl),
        .waddr      (wr_idx_reg),
        .cnt_wdata  (mem_wdata),
        .code_wdata (code_reg),
        .raddr      (idx_reg),
        .cnt_rdata  (mem_cnt),
        .code_rdata (mem_code)
    );

    ctb_expiry_fifo #(
        .NUM_TIMERS (NUM_TIMERS),
        .IW         (IW),
        .FW         (FW)
    ) u_expiry_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .push_data (wr_idx_reg),
        .head_data (fifo_head),
        .fill      (fifo_fill)
    );

    // status of the slot under the write index feeds both commands and the walk
    assign cur_st = status_reg[wr_idx_reg];

    ctb_tick_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tick_unit (
        .status    (cur_st),
        .count_in  (mem_cnt),
        .flags     (tick_flags),
        .count_new (tick_count)
    );

    // handshake
    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign in_slot_ok = (32'(slot) < NUM_TIMERS);
    assign in_idx     = in_slot_ok ? IW'(slot) : '0;

    // start with zero value keeps the stored count
    assign start_cnt  = (val_reg != '0) ? val_reg : mem_cnt;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        code_next       = code_reg;
        ok_next         = ok_reg;
        idx_next        = idx_reg;
        wr_idx_next     = wr_idx_reg;
        pipe_vld_next   = pipe_vld_reg;
        issue_done_next = issue_done_reg;
        status_next     = status_reg;
        run_cnt_next    = run_cnt_reg;
        armed_next      = armed_reg;
        res_next        = res_reg;
        out_res_next    = out_res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_ctrl        = '0;
        mem_wdata       = val_reg;
        fifo_ctrl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = ctb_cmd_t'(command);
                    val_next    = COUNT_WIDTH'(value);
                    code_next   = start_code;
                    ok_next     = in_slot_ok;
                    idx_next    = in_idx;
                    wr_idx_next = in_idx;
                    res_next    = '0;
                    case (ctb_cmd_t'(command))
                        CMD_TICK:
                        begin
                            if (armed_reg)
                            begin
                                // walk starts at slot zero
                                idx_next        = '0;
                                pipe_vld_next   = 1'b0;
                                issue_done_next = 1'b0;
                                state_next      = ST_WALK;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_NOP:
                        begin
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_CMD_WAIT;
                        end
                    endcase
                end
            end

            // count memory read in flight
            ST_CMD_WAIT:
            begin
                state_next = ST_CMD_EX;
            end

            ST_CMD_EX:
            begin
                case (cmd_reg)
                    CMD_START:
                    begin
                        if (ok_reg)
                        begin
                            if (cur_st != SLOT_QUEUED)
                            begin
                                mem_ctrl.cnt_we          = 1'b1;
                                mem_ctrl.code_we         = 1'b1;
                                mem_wdata                = start_cnt;
                                status_next[wr_idx_reg]  = SLOT_RUN;
                                if (cur_st != SLOT_RUN)
                                begin
                                    run_cnt_next = run_cnt_reg + FW'(1);
                                end
                                armed_next     = 1'b1;
                                res_next.count = OUT_W'(start_cnt);
                            end
                            else
                            begin
                                // queued slot ignores start
                                res_next.count = OUT_W'(mem_cnt);
                            end
                        end
                    end
                    CMD_SET:
                    begin
                        if (ok_reg)
                        begin
                            mem_ctrl.cnt_we = 1'b1;
                        end
                    end
                    CMD_GET:
                    begin
                        if (ok_reg)
                        begin
                            res_next.count = OUT_W'(mem_cnt);
                        end
                    end
                    CMD_PAUSE:
                    begin
                        if (ok_reg && cur_st == SLOT_RUN)
                        begin
                            status_next[wr_idx_reg] = SLOT_PAUSE;
                            run_cnt_next            = run_cnt_reg - FW'(1);
                            res_next.count          = OUT_W'(mem_cnt);
                        end
                        else
                        begin
                            res_next.error = 1'b1;
                        end
                        if (run_cnt_next == '0 && fifo_fill == '0)
                        begin
                            armed_next = 1'b0;
                        end
                    end
                    CMD_STOP:
                    begin
                        if (ok_reg && (cur_st inside {SLOT_RUN, SLOT_PAUSE}))
                        begin
                            status_next[wr_idx_reg] = SLOT_IDLE;
                            if (cur_st == SLOT_RUN)
                            begin
                                run_cnt_next = run_cnt_reg - FW'(1);
                            end
                            res_next.count = OUT_W'(mem_cnt);
                        end
                        else
                        begin
                            res_next.error = 1'b1;
                        end
                        if (run_cnt_next == '0 && fifo_fill == '0)
                        begin
                            armed_next = 1'b0;
                        end
                    end
                    CMD_RESUME:
                    begin
                        if (ok_reg && cur_st == SLOT_PAUSE)
                        begin
                            status_next[wr_idx_reg] = SLOT_RUN;
                            run_cnt_next            = run_cnt_reg + FW'(1);
                            res_next.count          = OUT_W'(mem_cnt);
                        end
                        else
                        begin
                            res_next.error = 1'b1;
                        end
                        if (run_cnt_next != '0 || fifo_fill != '0)
                        begin
                            armed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_EMIT;
            end

            // one slot read issued per cycle, the previous one decremented and written back
            ST_WALK:
            begin
                if (!issue_done_reg)
                begin
                    pipe_vld_next = 1'b1;
                    wr_idx_next   = idx_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
                else
                begin
                    pipe_vld_next = 1'b0;
                end

                if (pipe_vld_reg && tick_flags.run)
                begin
                    mem_ctrl.cnt_we = 1'b1;
                    mem_wdata       = tick_count;
                    if (tick_flags.expire)
                    begin
                        // timed out: park it in the queue in ascending slot order
                        status_next[wr_idx_reg] = SLOT_QUEUED;
                        run_cnt_next            = run_cnt_reg - FW'(1);
                        if (fifo_fill < FW'(NUM_TIMERS))
                        begin
                            fifo_ctrl.push = 1'b1;
                        end
                    end
                end

                if (issue_done_reg && !pipe_vld_reg)
                begin
                    state_next = ST_ARM;
                end
            end

            // re-arm decision, queue head read in flight
            ST_ARM:
            begin
                armed_next = (run_cnt_reg != '0) || (fifo_fill > FW'(1));
                if (fifo_fill != '0)
                begin
                    state_next = ST_Q_SLOT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            // deliver the head expiry, that slot goes idle
            ST_Q_SLOT:
            begin
                fifo_ctrl.pop          = 1'b1;
                idx_next               = fifo_head;
                wr_idx_next            = fifo_head;
                status_next[fifo_head] = SLOT_IDLE;
                res_next.exp_valid     = 1'b1;
                res_next.exp_slot      = SLOT_W'(fifo_head);
                state_next             = ST_C_WAIT;
            end

            // code memory read in flight
            ST_C_WAIT:
            begin
                state_next = ST_C_DATA;
            end

            ST_C_DATA:
            begin
                res_next.exp_code = mem_code;
                state_next        = ST_EMIT;
            end

            // hand the result to the output register once it is free
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_res_next   = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pipe_vld_reg   <= 1'b0;
            issue_done_reg <= 1'b0;
            run_cnt_reg    <= '0;
            armed_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                status_reg[i] <= SLOT_IDLE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pipe_vld_reg   <= pipe_vld_next;
            issue_done_reg <= issue_done_next;
            run_cnt_reg    <= run_cnt_next;
            armed_reg      <= armed_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        val_reg     <= val_next;
        code_reg    <= code_next;
        ok_reg      <= ok_next;
        idx_reg     <= idx_next;
        wr_idx_reg  <= wr_idx_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
    end

    // result channel
    assign out_valid    = out_valid_reg;
    assign count_out    = out_res_reg.count;
    assign error        = out_res_reg.error;
    assign expiry_valid = out_res_reg.exp_valid;
    assign expiry_slot  = out_res_reg.exp_slot;
    assign expiry_code  = out_res_reg.exp_code;

`ifndef SYNTHESIS
    // every slot is counted at most once as running or queued
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(run_cnt_reg) + 32'(fifo_fill)) <= NUM_TIMERS)
    else $error("running plus queued slots exceed the bank size");

    // write-back pipeline only carries data during the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld_reg |-> (state_reg == ST_WALK))
    else $error("walk pipeline valid outside the walk");

    // a pop never hits an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctrl.pop |-> (fifo_fill != '0))
    else $error("expiry queue popped while empty");

    // a fetched expiry code always belongs to a delivered expiry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_C_DATA) |-> res_reg.exp_valid)
    else $error("expiry code fetched without a delivered expiry");
`endif

endmodule
